>>> rtl/dbst_pkg.sv
// Package for the diagonal band score table: sizes, opcodes and the
// front-to-back queue entry type. No dependencies.
`timescale 1ns / 1ps
package dbst_pkg;
    localparam int BAND_COUNT = 1024;
    localparam int POS_BITS   = 32;
    localparam int SCORE_BITS = 32;
    localparam int BAND_BITS  = $clog2(BAND_COUNT);
    localparam int COV_BITS   = 33;
    localparam int USED_BITS  = 11;
    localparam int LEN_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [USED_BITS-1:0] USED_MAX = '1;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_CLRALL = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_KEY_ON_B = 2'd0,
        CFG_A_MAX    = 2'd1,
        CFG_B_MAX    = 2'd2,
        CFG_LOG_BW   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_READ  = 3'd1,
        ST_WRITE = 3'd2,
        ST_DONE  = 3'd3,
        ST_CLEAR = 3'd4
    } t_back_state;

    // classified item handed from front to back
    typedef struct packed {
        t_opcode               op;
        logic                  oor;
        logic [BAND_BITS-1:0]  band;
        logic [POS_BITS-1:0]   key;
        logic [LEN_BITS-1:0]   len;
    } t_job;
endpackage

>>> rtl/dbst_if.sv
// Valid/ready channel interfaces for input items, result items and
// configuration writes. Depends on dbst_pkg.
`timescale 1ns / 1ps
interface dbst_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [dbst_pkg::POS_BITS-1:0] apos;
    logic [dbst_pkg::POS_BITS-1:0] bpos;
    logic [dbst_pkg::LEN_BITS-1:0] match_len;
    modport source (output valid, opcode, apos, bpos, match_len, input ready);
    modport sink   (input valid, opcode, apos, bpos, match_len, output ready);
endinterface

interface dbst_out_if;
    logic                           valid;
    logic                           ready;
    logic [dbst_pkg::COV_BITS-1:0]  coverage;
    logic [dbst_pkg::USED_BITS-1:0] used_count;
    logic                           table_empty;
    logic                           out_of_range;
    modport source (output valid, coverage, used_count, table_empty, out_of_range,
                    input ready);
    modport sink   (input valid, coverage, used_count, table_empty, out_of_range,
                    output ready);
endinterface

interface dbst_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dbst_pkg::CFG_IDX_BITS-1:0]  index;
    logic [dbst_pkg::CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/dbst_front.sv
// Front end: config registers, band computation and range check.
// Depends on dbst_pkg.
`timescale 1ns / 1ps
module dbst_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbst_in_if.sink                         in_ch,
    dbst_cfg_if.sink                        cfg_ch,
    output logic                            o_job_valid,
    input  logic                            i_job_ready,
    output dbst_pkg::t_job                  o_job
);
    import dbst_pkg::*;

    logic                r_key_on_b;
    logic [31:0]         r_a_max, r_b_max;
    logic [4:0]          r_log_bw;
    logic [POS_BITS:0]   sum;
    logic [POS_BITS-1:0] first;
    logic [POS_BITS:0]   diag;
    logic [POS_BITS:0]   shifted;
    t_job                job;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_on_b <= 1'b1;
            r_a_max    <= '0;
            r_b_max    <= '0;
            r_log_bw   <= '0;
        end else if (cfg_ch.valid) begin
            unique case (t_cfg_idx'(cfg_ch.index))
                CFG_KEY_ON_B: r_key_on_b <= cfg_ch.data[0];
                CFG_A_MAX:    r_a_max    <= cfg_ch.data;
                CFG_B_MAX:    r_b_max    <= cfg_ch.data;
                CFG_LOG_BW:   r_log_bw   <= cfg_ch.data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_key_on_b) begin
            sum   = {1'b0, r_a_max} + {1'b0, in_ch.bpos};
            first = in_ch.apos;
        end else begin
            sum   = {1'b0, r_b_max} + {1'b0, in_ch.apos};
            first = in_ch.bpos;
        end
        diag    = sum - {1'b0, first};
        shifted = diag >> r_log_bw;
        job.op   = t_opcode'(in_ch.opcode);
        job.oor  = (sum < {1'b0, first}) || (shifted >= (POS_BITS+1)'(BAND_COUNT));
        job.band = shifted[BAND_BITS-1:0];
        job.key  = r_key_on_b ? in_ch.bpos : in_ch.apos;
        job.len  = in_ch.match_len;
        if (job.op == OP_CLRALL) job.oor = 1'b0;
    end

    assign o_job_valid = in_ch.valid;
    assign in_ch.ready = i_job_ready;
    assign o_job       = job;
endmodule

>>> rtl/dbst_fifo.sv
// Two-entry queue between front and back end. Depends on dbst_pkg.
`timescale 1ns / 1ps
module dbst_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dbst_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output dbst_pkg::t_job o_job
);
    import dbst_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count step");
endmodule

>>> rtl/dbst_back.sv
// Back end: band memories, read-modify-write sequencer, clearing sweep and
// output register. Depends on dbst_pkg.
`timescale 1ns / 1ps
module dbst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  dbst_pkg::t_job i_job,
    dbst_out_if.source     out_ch
);
    import dbst_pkg::*;

    // score and last key live in one word per band
    logic [SCORE_BITS+POS_BITS-1:0] r_mem [BAND_COUNT];
    logic [SCORE_BITS+POS_BITS-1:0] r_rd;
    logic [BAND_BITS-1:0]           rd_addr;
    logic [BAND_BITS-1:0]           r_clr_addr;   // clearing pass pointer

    logic                           wr_en;
    logic [BAND_BITS-1:0]           wr_addr;
    logic [SCORE_BITS+POS_BITS-1:0] wr_data;

    t_back_state r_st, n_st;
    t_job        r_job;
    logic [1:0]  r_phase;                         // which of three reads
    logic [SCORE_BITS-1:0] r_s_c, r_s_lo;
    logic [USED_BITS-1:0]  r_used;
    logic                  r_ovalid;
    logic [COV_BITS-1:0]   r_cov;
    logic                  r_oor;

    logic [SCORE_BITS-1:0] rd_score, cur_s, add, sat_s, nb;
    logic [POS_BITS-1:0]   cur_last;
    logic                  do_wr, rd_ok;
    logic [SCORE_BITS:0]   sum_s;
    logic [COV_BITS-1:0]   cov_sum;
    logic                  phase_ok;
    logic                  out_free, take, set_ov;

    assign out_ch.valid        = r_ovalid;
    assign out_ch.coverage     = r_cov;
    assign out_ch.used_count   = r_used;
    assign out_ch.table_empty  = (r_used == '0);
    assign out_ch.out_of_range = r_oor;

    assign out_free    = !r_ovalid || out_ch.ready;
    assign o_job_ready = (r_st == ST_RUN) && out_free;
    assign take        = i_job_valid && o_job_ready;

    // read address per phase: centre, then below, then above
    always_comb begin
        unique case (r_phase)
            2'd1:    rd_addr = r_job.band - BAND_BITS'(1);
            2'd2:    rd_addr = r_job.band + BAND_BITS'(1);
            default: rd_addr = r_job.band;
        endcase
    end

    // single write port: clearing pass, clear band, update write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_job.band;
        wr_data = '0;
        if (r_st == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
        end else if (r_st == ST_RUN && take && i_job.op == OP_CLEAR && !i_job.oor) begin
            wr_en   = 1'b1;
            wr_addr = i_job.band;
        end else if (r_st == ST_WRITE && r_job.op == OP_UPDATE && do_wr) begin
            wr_en   = 1'b1;
            wr_data = {sat_s, r_job.key};
        end
        if (!i_rst_n) wr_en = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    assign rd_score = r_rd[SCORE_BITS+POS_BITS-1:POS_BITS];
    assign cur_last = r_rd[POS_BITS-1:0];
    assign cur_s    = rd_score;

    always_comb begin
        do_wr = 1'b0;
        add   = '0;
        if (cur_last == '0 || (cur_last <= r_job.key && r_job.key - cur_last >= r_job.len)) begin
            do_wr = 1'b1; add = SCORE_BITS'(r_job.len);
        end else if (cur_last < r_job.key) begin
            do_wr = 1'b1; add = SCORE_BITS'(r_job.key - cur_last);
        end
        sum_s = {1'b0, cur_s} + {1'b0, add};
        sat_s = sum_s[SCORE_BITS] ? '1 : sum_s[SCORE_BITS-1:0];
    end

    // phase 2 result holds the upper neighbour
    assign phase_ok = !(r_phase == 2'd2 && r_job.band == BAND_BITS'(BAND_COUNT-1));
    always_comb begin
        logic [SCORE_BITS-1:0] hi;
        hi      = phase_ok ? rd_score : '0;
        nb      = (r_s_lo > hi) ? r_s_lo : hi;
        cov_sum = COV_BITS'(r_s_c) + COV_BITS'(nb);
    end
    assign rd_ok = 1'b1;

    // result raised at once for clears and out-of-range items, else at done
    assign set_ov = (r_st == ST_RUN && take &&
                     (i_job.op == OP_CLRALL || i_job.oor || i_job.op == OP_CLEAR)) ||
                    (r_st == ST_DONE && out_free);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_RUN: if (take) begin
                if (!i_job.oor && (i_job.op == OP_UPDATE || i_job.op == OP_QUERY))
                    n_st = ST_READ;
                else if (i_job.op == OP_CLRALL)
                    n_st = ST_CLEAR;
            end
            ST_READ:  n_st = ST_WRITE;
            ST_WRITE: if (r_job.op == OP_UPDATE || r_phase == 2'd2) n_st = ST_DONE;
                      else n_st = ST_READ;
            ST_DONE:  if (out_free) n_st = ST_RUN;
            ST_CLEAR: if (r_clr_addr == BAND_BITS'(BAND_COUNT-1)) n_st = ST_RUN;
            default:  n_st = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_CLEAR;
            r_clr_addr <= '0;
            r_used     <= '0;
            r_ovalid   <= 1'b0;
            r_phase    <= '0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= set_ov || (r_ovalid && !out_ch.ready);
            unique case (r_st)
                ST_RUN: if (take) begin
                    r_job   <= i_job;
                    r_phase <= '0;
                    r_cov   <= '0;
                    r_oor   <= i_job.oor;
                    if (i_job.op == OP_CLRALL || (!i_job.oor && i_job.op == OP_CLEAR))
                        r_used <= '0;
                end
                ST_READ: ;
                ST_WRITE: begin
                    if (r_job.op == OP_UPDATE) begin
                        if (do_wr && cur_s == '0 && sat_s != '0 && r_used != USED_MAX)
                            r_used <= r_used + USED_BITS'(1);
                    end else begin
                        unique case (r_phase)
                            2'd0: r_s_c  <= rd_score;
                            2'd1: r_s_lo <= (r_job.band == '0) ? '0 : rd_score;
                            default: r_cov <= cov_sum;
                        endcase
                        r_phase <= r_phase + 2'd1;
                    end
                end
                ST_DONE: ;
                ST_CLEAR: r_clr_addr <= r_clr_addr + BAND_BITS'(1);
                default: ;
            endcase
        end
    end

    a_ready_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> (r_st == ST_RUN)) else $error("accept outside run");
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.table_empty == (r_used == '0) && rd_ok) else $error("empty flag");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && out_free) |=> r_ovalid) else $error("result lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> (r_ovalid && $stable(r_cov) && $stable(r_oor)))
        else $error("waiting result changed");
endmodule

>>> rtl/diagonal_band_score_table_core.sv
// Top level of the diagonal band score table: front end, queue, back end.
// Depends on dbst_pkg, dbst_if, dbst_front, dbst_fifo, dbst_back.
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   opcode, apos, bpos, match_len
// out_ch    out  coverage, used_count, table_empty, out_of_range
// cfg_ch    in   index, data (key_on_b, a_max_len, b_max_len, log_band_width)
//
// Sequence: the queue registers each item between input and back end. From the
// back end taking an item: clears and out-of-range items give their result at
// once; an update goes through memory read, write-back and result, and a query
// through three reads of the single read port and then its result, before the
// back end is free again. Clear all gives its result at once, then a clearing
// pass over all 1024 bands zeroes the band memory before the next item. Reset
// starts the same pass. Either side may stall: the two-entry queue lets the
// front take items while the back end is busy.
module diagonal_band_score_table_core (
    input  logic i_clk,
    input  logic i_rst_n,
    dbst_in_if.sink    in_ch,
    dbst_out_if.source out_ch,
    dbst_cfg_if.sink   cfg_ch
);
    import dbst_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    dbst_front u_front (
        .i_clk, .i_rst_n, .in_ch, .cfg_ch,
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    // item queue between classification and table access
    dbst_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(b_valid), .i_ready(b_ready), .o_job(b_job)
    );

    dbst_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(b_valid), .o_job_ready(b_ready), .i_job(b_job), .out_ch
    );
endmodule
